/* sv/mktd_pkg.sv */
// ----------------------------------------------------------------------------
// Morse key timing decoder package
// Shared types, codes, register reset values and the Morse code lookup.
// ----------------------------------------------------------------------------
package mktd_pkg;

	localparam int ADDR_W      = 3;
	localparam int DATA_W      = 32;
	localparam int THR_W       = 16;
	localparam int KEY_W       = 3;
	localparam int CHAR_W      = 7;
	localparam int COUNT_W     = 4;
	localparam int CODE_MAX    = 5;

	localparam logic [THR_W-1:0] DOT_THR_RESET  = 16'd100;
	localparam logic [THR_W-1:0] DASH_THR_RESET = 16'd300;

	typedef enum logic {
		REG_DOT_THR  = 1'b0,
		REG_DASH_THR = 1'b1
	} reg_index_t;

	typedef enum logic {
		OP_TICK = 1'b0,
		OP_KEY  = 1'b1
	} operation_t;

	localparam logic [KEY_W-1:0] KEY_RELEASED   = 3'd0;
	localparam logic [KEY_W-1:0] KEY_SIGNAL     = 3'd1;
	localparam logic [KEY_W-1:0] KEY_LETTER_END = 3'd2;
	localparam logic [KEY_W-1:0] KEY_STOP       = 3'd4;

	typedef enum logic [2:0] {
		EV_IGNORED = 3'd0,
		EV_DOT     = 3'd1,
		EV_DASH    = 3'd2,
		EV_CHAR    = 3'd3,
		EV_UNKNOWN = 3'd4,
		EV_STOPPED = 3'd5
	} event_kind_t;

	typedef struct packed {
		logic [THR_W-1:0] dot;
		logic [THR_W-1:0] dash;
	} thresholds_t;

	typedef struct packed {
		logic               valid;
		event_kind_t        kind;
		logic [CHAR_W-1:0]  character;
		logic [COUNT_W-1:0] count;
	} result_t;

	// Symbol i of the pattern sits in bit i, a dot is 0 and a dash is 1.
	// Returns zero when the pattern is not a letter or a digit.
	function automatic logic [CHAR_W-1:0] morse_lookup(
		input logic [2:0]          len,
		input logic [CODE_MAX-1:0] pattern
	);
		logic [CODE_MAX-1:0] mask;
		logic [CHAR_W-1:0]   ch;
		mask = ~({CODE_MAX{1'b1}} << len);
		ch   = '0;
		case ({len, pattern & mask})
			{3'd2, 5'd2}:  ch = 7'h41; // A
			{3'd4, 5'd1}:  ch = 7'h42; // B
			{3'd4, 5'd5}:  ch = 7'h43; // C
			{3'd3, 5'd1}:  ch = 7'h44; // D
			{3'd1, 5'd0}:  ch = 7'h45; // E
			{3'd4, 5'd4}:  ch = 7'h46; // F
			{3'd3, 5'd3}:  ch = 7'h47; // G
			{3'd4, 5'd0}:  ch = 7'h48; // H
			{3'd2, 5'd0}:  ch = 7'h49; // I
			{3'd4, 5'd14}: ch = 7'h4A; // J
			{3'd3, 5'd5}:  ch = 7'h4B; // K
			{3'd4, 5'd2}:  ch = 7'h4C; // L
			{3'd2, 5'd3}:  ch = 7'h4D; // M
			{3'd2, 5'd1}:  ch = 7'h4E; // N
			{3'd3, 5'd7}:  ch = 7'h4F; // O
			{3'd4, 5'd6}:  ch = 7'h50; // P
			{3'd4, 5'd11}: ch = 7'h51; // Q
			{3'd3, 5'd2}:  ch = 7'h52; // R
			{3'd3, 5'd0}:  ch = 7'h53; // S
			{3'd1, 5'd1}:  ch = 7'h54; // T
			{3'd3, 5'd4}:  ch = 7'h55; // U
			{3'd4, 5'd8}:  ch = 7'h56; // V
			{3'd3, 5'd6}:  ch = 7'h57; // W
			{3'd4, 5'd9}:  ch = 7'h58; // X
			{3'd4, 5'd13}: ch = 7'h59; // Y
			{3'd4, 5'd3}:  ch = 7'h5A; // Z
			{3'd5, 5'd31}: ch = 7'h30; // 0
			{3'd5, 5'd30}: ch = 7'h31; // 1
			{3'd5, 5'd28}: ch = 7'h32; // 2
			{3'd5, 5'd24}: ch = 7'h33; // 3
			{3'd5, 5'd16}: ch = 7'h34; // 4
			{3'd5, 5'd0}:  ch = 7'h35; // 5
			{3'd5, 5'd1}:  ch = 7'h36; // 6
			{3'd5, 5'd3}:  ch = 7'h37; // 7
			{3'd5, 5'd7}:  ch = 7'h38; // 8
			{3'd5, 5'd15}: ch = 7'h39; // 9
			default:       ch = '0;
		endcase
		return ch;
	endfunction

endpackage

/* sv/morse_key_timing_decoder.sv */
// ----------------------------------------------------------------------------
// Morse key timing decoder
// Classifies key presses by duration and decodes Morse letters and digits.
// ----------------------------------------------------------------------------
// The block takes one request per clock cycle, millisecond ticks and key
// changes alike, and a request that causes an event passes through the input
// register and then the result register before it is delivered. Only a
// stalled result register holds back the input side, and ticks and unchanged
// keys pass through even then, since they produce no event.
module morse_key_timing_decoder
	import mktd_pkg::*;
#(
	parameter int MAX_SYMBOLS = 9,
	parameter int TIMER_BITS  = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               operation,
	input  logic [KEY_W-1:0]   key_value,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [2:0]         event_kind,
	output logic [CHAR_W-1:0]  character,
	output logic [COUNT_W-1:0] symbol_count,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [ADDR_W-1:0]  paddr,
	input  logic [DATA_W-1:0]  pwdata,
	output logic [DATA_W-1:0]  prdata,
	output logic               pready
);

	thresholds_t        thr;
	result_t            res;
	logic               valid_s1;
	logic               op_s1;
	logic [KEY_W-1:0]   key_s1;
	logic               advance;
	logic               out_valid_q;
	event_kind_t        kind_q;
	logic [CHAR_W-1:0]  char_q;
	logic [COUNT_W-1:0] count_q;

	mktd_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.thr     (thr)
	);

	mktd_core #(
		.MAX_SYMBOLS (MAX_SYMBOLS),
		.TIMER_BITS  (TIMER_BITS)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.operation (op_s1),
		.key_value (key_s1),
		.thr       (thr),
		.res       (res)
	);

	assign advance  = valid_s1 && (!res.valid || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_s1  <= operation;
			key_s1 <= key_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && res.valid) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res.valid) begin
			kind_q  <= res.kind;
			char_q  <= res.character;
			count_q <= res.count;
		end
	end

	assign out_valid    = out_valid_q;
	assign event_kind   = kind_q;
	assign character    = char_q;
	assign symbol_count = count_q;

endmodule

/* sv/mktd_cfg_regs.sv */
// ----------------------------------------------------------------------------
// Morse key timing decoder configuration registers
// APB register file holding the dot and dash duration thresholds.
// ----------------------------------------------------------------------------
module mktd_cfg_regs
	import mktd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output thresholds_t       thr
);

	logic [THR_W-1:0] dot_q;
	logic [THR_W-1:0] dash_q;
	reg_index_t       index;
	logic             wr_en;

	assign index  = reg_index_t'(paddr[2]);
	assign wr_en  = psel & penable & pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dot_q  <= DOT_THR_RESET;
			dash_q <= DASH_THR_RESET;
		end else if (wr_en) begin
			case (index)
				REG_DOT_THR:  dot_q  <= pwdata[THR_W-1:0];
				REG_DASH_THR: dash_q <= pwdata[THR_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (index)
			REG_DOT_THR:  prdata = DATA_W'(dot_q);
			REG_DASH_THR: prdata = DATA_W'(dash_q);
			default:      prdata = '0;
		endcase
	end

	assign thr.dot  = dot_q;
	assign thr.dash = dash_q;

endmodule

/* sv/mktd_core.sv */
// ----------------------------------------------------------------------------
// Morse key timing decoder core
// Press timer, symbol pattern and key state, with the per-item event logic.
// ----------------------------------------------------------------------------
module mktd_core
	import mktd_pkg::*;
#(
	parameter int MAX_SYMBOLS = 9,
	parameter int TIMER_BITS  = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  logic             operation,
	input  logic [KEY_W-1:0] key_value,
	input  thresholds_t      thr,
	output result_t          res
);

	localparam int LEN_W = $clog2(MAX_SYMBOLS + 1);
	localparam int IDX_W = $clog2(MAX_SYMBOLS);
	localparam int CMP_W = (TIMER_BITS > THR_W) ? TIMER_BITS : THR_W;

	logic [TIMER_BITS-1:0]  timer_q, timer_n;
	logic [MAX_SYMBOLS-1:0] pattern_q, pattern_n;
	logic [LEN_W-1:0]       len_q, len_n;
	logic [KEY_W-1:0]       prev_q, prev_n;
	logic                   stopped_q, stopped_n;

	logic [CMP_W-1:0]  dur;
	logic [CMP_W-1:0]  dot_x;
	logic [CMP_W-1:0]  dash_x;
	logic [CHAR_W-1:0] decoded;
	logic              len_ok;

	assign dur    = CMP_W'(timer_q);
	assign dot_x  = CMP_W'(thr.dot);
	assign dash_x = CMP_W'(thr.dash);
	assign len_ok = (len_q != '0) && (len_q <= LEN_W'(CODE_MAX));
	assign decoded = morse_lookup(len_q[2:0], pattern_q[CODE_MAX-1:0]);

	always_comb begin
		timer_n       = timer_q;
		pattern_n     = pattern_q;
		len_n         = len_q;
		prev_n        = prev_q;
		stopped_n     = stopped_q;
		res.valid     = 1'b0;
		res.kind      = EV_IGNORED;
		res.character = '0;
		if (!stopped_q) begin
			if (operation == OP_TICK) begin
				if (timer_q != '1) begin
					timer_n = timer_q + TIMER_BITS'(1);
				end
			end else if (key_value != prev_q) begin
				res.valid = 1'b1;
				prev_n    = key_value;
				case (key_value)
					KEY_STOP: begin
						stopped_n = 1'b1;
						res.kind  = EV_STOPPED;
					end
					KEY_LETTER_END: begin
						if (len_ok && decoded != '0) begin
							res.kind      = EV_CHAR;
							res.character = decoded;
						end else begin
							res.kind = EV_UNKNOWN;
						end
						pattern_n = '0;
						len_n     = '0;
					end
					KEY_SIGNAL: begin
						timer_n = '0;
					end
					KEY_RELEASED: begin
						if (prev_q != KEY_LETTER_END && len_q < LEN_W'(MAX_SYMBOLS)) begin
							if (dur > dot_x && dur < dash_x) begin
								pattern_n[len_q[IDX_W-1:0]] = 1'b0;
								len_n    = len_q + LEN_W'(1);
								res.kind = EV_DOT;
							end else if (dur >= dash_x) begin
								pattern_n[len_q[IDX_W-1:0]] = 1'b1;
								len_n    = len_q + LEN_W'(1);
								res.kind = EV_DASH;
							end
						end
					end
					default: ;
				endcase
			end
		end
		res.count = COUNT_W'(len_n);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timer_q   <= '0;
			pattern_q <= '0;
			len_q     <= '0;
			prev_q    <= KEY_RELEASED;
			stopped_q <= 1'b0;
		end else if (step) begin
			timer_q   <= timer_n;
			pattern_q <= pattern_n;
			len_q     <= len_n;
			prev_q    <= prev_n;
			stopped_q <= stopped_n;
		end
	end

endmodule

/* tb/morse_key_timing_decoder_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Morse key timing decoder testbench
// Drives ticks and key changes through the request channel and checks every
// event against a cycle-free model of the timer, the symbol pattern and the
// letter decode, under several dot and dash threshold settings.
// ----------------------------------------------------------------------------
module morse_key_timing_decoder_tb;
	import mktd_pkg::*;

	localparam int PATTERN_MAX = 9;
	localparam logic [THR_W-1:0] THR_MAX = '1;

	class morse_scoreboard;
		typedef struct {
			event_kind_t        kind;
			logic [CHAR_W-1:0]  ch;
			logic [COUNT_W-1:0] count;
		} decoded_t;

		logic [THR_W-1:0]       dot_thr;
		logic [THR_W-1:0]       dash_thr;
		logic [15:0]            press_ms;
		logic [PATTERN_MAX-1:0] pattern;
		int unsigned            held;
		logic [KEY_W-1:0]       last_key;
		bit                     halted;
		string                  codes[36];
		string                  letters;
		decoded_t               awaited[$];
		int unsigned            failures;
		int unsigned            checked;

		function new();
			codes = '{".-", "-...", "-.-.", "-..", ".", "..-.", "--.", "....", "..",
				".---", "-.-", ".-..", "--", "-.", "---", ".--.", "--.-", ".-.",
				"...", "-", "..-", "...-", ".--", "-..-", "-.--", "--..", "-----",
				".----", "..---", "...--", "....-", ".....", "-....", "--...",
				"---..", "----."};
			letters  = "ABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789";
			dot_thr  = DOT_THR_RESET;
			dash_thr = DASH_THR_RESET;
			press_ms = '0;
			pattern  = '0;
			held     = 0;
			last_key = KEY_RELEASED;
			halted   = 0;
			failures = 0;
			checked  = 0;
		endfunction

		function void set_threshold(reg_index_t idx, logic [THR_W-1:0] value);
			if (idx == REG_DOT_THR)
				dot_thr = value;
			else
				dash_thr = value;
		endfunction

		function logic [CHAR_W-1:0] letter_for();
			bit hit;
			if (held == 0 || held > CODE_MAX)
				return '0;
			for (int k = 0; k < 36; k++) begin
				if (codes[k].len() == held) begin
					hit = 1;
					for (int i = 0; i < held; i++) begin
						if (pattern[i] != (codes[k][i] == "-"))
							hit = 0;
					end
					if (hit)
						return CHAR_W'(letters[k]);
				end
			end
			return '0;
		endfunction

		function void note_request(operation_t op, logic [KEY_W-1:0] key);
			decoded_t    r;
			event_kind_t sym;
			logic [CHAR_W-1:0] c;
			if (halted)
				return;
			if (op == OP_TICK) begin
				if (press_ms != '1)
					press_ms++;
				return;
			end
			if (key == last_key)
				return;
			r.kind = EV_IGNORED;
			r.ch   = '0;
			if (key == KEY_STOP) begin
				halted = 1;
				r.kind = EV_STOPPED;
			end else if (key == KEY_LETTER_END) begin
				c = letter_for();
				r.kind  = (c != '0) ? EV_CHAR : EV_UNKNOWN;
				r.ch    = c;
				pattern = '0;
				held    = 0;
			end else if (key == KEY_SIGNAL) begin
				press_ms = '0;
			end else if (key == KEY_RELEASED && last_key != KEY_LETTER_END) begin
				sym = EV_IGNORED;
				if (press_ms > dot_thr && press_ms < dash_thr)
					sym = EV_DOT;
				else if (press_ms >= dash_thr)
					sym = EV_DASH;
				if (sym != EV_IGNORED && held < PATTERN_MAX) begin
					pattern[held] = (sym == EV_DASH);
					held++;
					r.kind = sym;
				end
			end
			last_key = key;
			r.count  = COUNT_W'(held);
			awaited.push_back(r);
		endfunction

		function void check_result(logic [2:0] kind, logic [CHAR_W-1:0] ch,
			logic [COUNT_W-1:0] count);
			decoded_t e;
			checked++;
			if (awaited.size() == 0) begin
				$display("%0t: unexpected event kind=%0d char=%0h count=%0d",
					$time, kind, ch, count);
				failures++;
				return;
			end
			e = awaited.pop_front();
			if (kind !== e.kind) begin
				$display("%0t: event_kind expected %0d actual %0d", $time, e.kind, kind);
				failures++;
			end
			if (ch !== e.ch) begin
				$display("%0t: character expected %0h actual %0h", $time, e.ch, ch);
				failures++;
			end
			if (count !== e.count) begin
				$display("%0t: symbol_count expected %0d actual %0d",
					$time, e.count, count);
				failures++;
			end
		endfunction

		function int pending();
			return awaited.size();
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic               operation = 1'b0;
	logic [KEY_W-1:0]   key_value = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [2:0]         event_kind;
	logic [CHAR_W-1:0]  character;
	logic [COUNT_W-1:0] symbol_count;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [ADDR_W-1:0]  paddr = '0;
	logic [DATA_W-1:0]  pwdata = '0;
	logic [DATA_W-1:0]  prdata;
	logic               pready;

	morse_scoreboard book = new();
	bit          no_idle = 0;
	bit          hold_done = 0;
	int          hold_left = 0;
	int unsigned sent_reqs = 0;
	int unsigned settings_used = 0;
	logic [THR_W-1:0] phase_dot[6] = '{16'd2, 16'd0, 16'd4, 16'd6, 16'd1, 16'd0};
	logic [THR_W-1:0] phase_dash[6] = '{16'd5, 16'd3, 16'd4, 16'd2, THR_MAX, 16'd0};

	morse_key_timing_decoder u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.operation(operation),
		.key_value(key_value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.event_kind(event_kind),
		.character(character),
		.symbol_count(symbol_count),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("Timed out with %0d events still awaited.", book.pending());
		$display("morse_key_timing_decoder_tb NOT OK");
		$finish;
	end

	// The receiver stalls at random and once holds off long enough to back up
	// the block while requests keep coming.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			book.check_result(event_kind, character, symbol_count);
		if (hold_left > 0) begin
			hold_left--;
		end else if (!hold_done && book.checked >= 50 && in_valid) begin
			hold_left = 400;
			hold_done = 1;
		end
		out_ready <= (hold_left == 0) && (no_idle || $urandom_range(0, 99) >= 9);
	end

	task automatic send_req(input operation_t op, input logic [KEY_W-1:0] key);
		if (!no_idle && $urandom_range(0, 99) < 9) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		operation <= op;
		key_value <= key;
		do @(posedge clk); while (!in_ready);
		book.note_request(op, key);
		sent_reqs++;
	endtask

	task automatic press_key(input logic [KEY_W-1:0] key);
		send_req(OP_KEY, key);
	endtask

	task automatic tick(input int n);
		repeat (n) send_req(OP_TICK, KEY_W'($urandom_range(0, 7)));
	endtask

	task automatic key_symbol(input int ms);
		press_key(KEY_SIGNAL);
		tick(ms);
		press_key(KEY_RELEASED);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (book.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input reg_index_t idx, input logic [THR_W-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_W'(4 * int'(idx));
		pwdata  <= DATA_W'(value);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		book.set_threshold(idx, value);
	endtask

	task automatic set_thresholds(input logic [THR_W-1:0] dot, input logic [THR_W-1:0] dash);
		drain();
		write_reg(REG_DOT_THR, dot);
		write_reg(REG_DASH_THR, dash);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		settings_used++;
	endtask

	task automatic random_phase(input int n_reqs, input int max_ms);
		int unsigned goal;
		int          n_sym;
		logic [KEY_W-1:0] k;
		goal = sent_reqs + n_reqs;
		while (sent_reqs < goal) begin
			if ($urandom_range(0, 99) < 80) begin
				n_sym = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 11)
					: $urandom_range(1, 5);
				repeat (n_sym) key_symbol($urandom_range(0, max_ms));
				press_key(KEY_LETTER_END);
				if ($urandom_range(0, 1))
					press_key(KEY_RELEASED);
			end else begin
				repeat ($urandom_range(1, 6)) begin
					k = KEY_W'($urandom_range(0, 7));
					if (k == KEY_STOP)
						k = KEY_STOP | KEY_SIGNAL;
					send_req(operation_t'($urandom_range(0, 1)), k);
				end
			end
		end
	endtask

	initial begin
		int lim;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		press_key(KEY_RELEASED);
		key_symbol(101);
		key_symbol(100);
		key_symbol(300);
		press_key(KEY_LETTER_END);
		press_key(KEY_LETTER_END);
		press_key(KEY_RELEASED);
		press_key(KEY_LETTER_END);
		press_key(KEY_SIGNAL | KEY_LETTER_END);
		press_key(KEY_STOP | KEY_SIGNAL);
		press_key(KEY_STOP | KEY_LETTER_END);
		press_key(KEY_STOP | KEY_LETTER_END | KEY_SIGNAL);
		press_key(KEY_RELEASED);
		press_key(KEY_LETTER_END);

		set_thresholds(16'd1, 16'd3);
		repeat (10) key_symbol(2);
		press_key(KEY_LETTER_END);
		repeat (6) key_symbol(3);
		press_key(KEY_LETTER_END);
		repeat (5) key_symbol(2);
		press_key(KEY_LETTER_END);

		set_thresholds(THR_MAX, THR_MAX);
		key_symbol(3);
		press_key(KEY_LETTER_END);
		set_thresholds(16'd0, 16'd0);
		key_symbol(0);
		set_thresholds(16'd0, THR_MAX);
		key_symbol(0);
		key_symbol(1);
		press_key(KEY_LETTER_END);

		for (int p = 0; p < 6; p++) begin
			set_thresholds(phase_dot[p], phase_dash[p]);
			no_idle = (p == 1 || p == 2);
			lim = int'((phase_dot[p] > phase_dash[p]) ? phase_dot[p] : phase_dash[p]);
			if (lim > 8)
				lim = 8;
			random_phase(30, lim + 2);
		end
		no_idle = 0;

		press_key(KEY_STOP);
		repeat (6) send_req(operation_t'($urandom_range(0, 1)), KEY_W'($urandom_range(0, 7)));
		in_valid <= 1'b0;

		for (int i = 0; i < 2000 && book.pending() != 0; i++) @(posedge clk);
		repeat (8) @(posedge clk);
		if (book.pending() != 0) begin
			$display("%0t: %0d expected events never arrived", $time, book.pending());
			book.failures++;
		end

		$display("Sent %0d requests and checked %0d events over %0d threshold settings,",
			sent_reqs, book.checked, settings_used);
		$display("including a full pattern, long symbol runs, back-pressure and stop.");
		if (book.failures == 0)
			$display("morse_key_timing_decoder_tb OK");
		else
			$display("morse_key_timing_decoder_tb NOT OK");
		$finish;
	end

endmodule
